[design/weighted_degree_kernel_assert.svh]
// Assertion macros for the weighted degree kernel block.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef WEIGHTED_DEGREE_KERNEL_ASSERT_SVH
`define WEIGHTED_DEGREE_KERNEL_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define WDK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define WDK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wdk_pkg.sv]
// Shared types and constants for the weighted degree kernel block.
// No dependencies.
package wdk_pkg;

  localparam int SymW       = 8;
  localparam int WeightW    = 25;
  localparam int SumW       = 41;
  localparam int RunW       = 4;
  localparam int NumWeights = 8;
  localparam int CfgIdxW    = 3;
  localparam int InDataW    = 2 * SymW;
  localparam int OutDataW   = 48;

  typedef logic [SymW-1:0]    sym_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [SumW-1:0]    sum_t;
  typedef logic [RunW-1:0]    run_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Longest run that selects its own weight.
  localparam run_t MaxDegree = run_t'(8);
  localparam sum_t SumMax    = {SumW{1'b1}};

endpackage

[design/weighted_degree_kernel.sv]
// Weighted degree string kernel: out_tvalid rises after a last pair passes the input register,
// then the result register; throughput one symbol pair per cycle while no last pair is held back.
// Run update, weight select and saturating add are combinational between the two registers.
// The result register decouples the sides; only a last pair waits on a full result register.
// Reset (rst_n low, synchronous) clears the run, the sum, the weights and both valid flags.
// Depends on wdk_pkg and weighted_degree_kernel_assert.svh.
`include "weighted_degree_kernel_assert.svh"

module weighted_degree_kernel (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  wdk_pkg::cfg_idx_t             cfg_index,
  input  wdk_pkg::weight_t              cfg_data,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wdk_pkg::InDataW-1:0]   in_tdata,   // [7:0] symbol_a, [15:8] symbol_b
  input  logic                          in_tlast,   // is_last
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wdk_pkg::OutDataW-1:0]  out_tdata   // [40:0] kernel_value, [47:41] zero
);
  import wdk_pkg::*;

  weight_t cum_weight_r [NumWeights];

  logic s1_valid_r;
  sym_t s1_sym_a_r;
  sym_t s1_sym_b_r;
  logic s1_last_r;

  run_t run_r;
  run_t run_nxt;
  sum_t sum_r;
  sum_t sum_nxt;

  logic out_valid_r;
  sum_t out_value_r;

  logic                 s1_adv;
  logic                 match;
  run_t                 run_inc;
  run_t                 run_sel;
  weight_t              weight;
  logic [SumW:0]        sum_wide;
  sum_t                 sum_acc;

  // Configuration writes are always taken; every index names a register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NumWeights; k++) begin
        cum_weight_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      cum_weight_r[cfg_index] <= cfg_data;
    end
  end

  // Stage one drains unless it holds a last pair and the result register is still full.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sym_a_r <= in_tdata[SymW-1:0];
      s1_sym_b_r <= in_tdata[InDataW-1:SymW];
      s1_last_r  <= in_tlast;
    end
  end

  // Run length update, capped at the maximum degree.
  assign match   = (s1_sym_a_r == s1_sym_b_r);
  assign run_inc = (run_r >= MaxDegree) ? MaxDegree : run_r + run_t'(1);
  assign run_sel = run_inc - run_t'(1);
  assign weight  = cum_weight_r[run_sel[CfgIdxW-1:0]];

  // Saturating accumulate.
  assign sum_wide = {1'b0, sum_r} + {{(SumW + 1 - WeightW){1'b0}}, weight};
  assign sum_acc  = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];

  always_comb begin
    run_nxt = run_r;
    sum_nxt = sum_r;
    if (s1_adv) begin
      if (match) begin
        run_nxt = run_inc;
        sum_nxt = sum_acc;
      end else begin
        run_nxt = '0;
      end
      if (s1_last_r) begin
        run_nxt = '0;
        sum_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      sum_r <= '0;
    end else begin
      run_r <= run_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Result register: loaded by a last pair, emptied by an output transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_value_r <= match ? sum_acc : sum_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - SumW){1'b0}}, out_value_r};

  // Checks on the run counter, the accumulator and the result register.
  `WDK_ASSERT_IMPL(a_run_capped, 1'b1, run_r <= MaxDegree, "match run exceeds the maximum degree")
  `WDK_ASSERT_NEXT(a_last_clears, s1_adv && s1_last_r, run_r == '0 && sum_r == '0,
                   "state not cleared after a last pair")
  `WDK_ASSERT_NEXT(a_last_loads, s1_adv && s1_last_r, out_valid_r,
                   "last pair produced no result")
  `WDK_ASSERT_NEXT(a_mismatch_resets, s1_adv && !match, run_r == '0,
                   "mismatch did not reset the match run")
  `WDK_ASSERT_NEXT(a_sum_monotonic, s1_adv && !s1_last_r, sum_r >= $past(sum_r),
                   "running sum decreased within a string pair")

endmodule
